// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/wlfs_pkg.sv =====
`timescale 1ns / 1ps
package wlfs_pkg;

  localparam int LEVEL_BITS     = 24;
  localparam int CABLE_BITS     = 23;
  localparam int TIME_BITS      = 32;
  localparam int THRESH_BITS    = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int QUEUE_DEPTH    = 2;

  // Window bounds after a clear
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_TOP    = {1'b0, {(LEVEL_BITS-1){1'b1}}};
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_BOTTOM =
    {1'b1, {(LEVEL_BITS-2){1'b0}}, 1'b1};

  // Register reset values
  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = THRESH_BITS'(20);
  localparam logic [TIME_BITS-1:0]   WINDOW_RESET    = '0;
  localparam logic [CABLE_BITS-1:0]  NEAR_ZERO_RESET = CABLE_BITS'(1000);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STABLE_THRESHOLD = 2'd0,
    REG_WINDOW_LEN       = 2'd1,
    REG_ZERO_NEAR_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_UP        = 2'd1,
    CMD_DOWN      = 2'd2,
    CMD_SLOW_STOP = 2'd3
  } motor_cmd_t;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_STABLE    = 2'd1,
    ST_TOO_LOW   = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  typedef struct packed {
    action_t                       action;
    logic                          in_water;
    logic [CABLE_BITS-1:0]         cable_len;
    logic signed [LEVEL_BITS-1:0]  level_now;
    logic [TIME_BITS-1:0]          now_ms;
  } req_t;

  typedef struct packed {
    motor_cmd_t                    motor_cmd;
    status_t                       status;
    logic                          level_valid;
    logic signed [LEVEL_BITS-1:0]  level_avg;
    logic                          window_reset;
  } rsp_t;

  // Request after classification by the front end
  typedef struct packed {
    action_t                       action;
    logic                          in_water;
    logic                          near_zero;
    logic signed [LEVEL_BITS-1:0]  level_half;
    logic                          level_odd;
    logic [TIME_BITS-1:0]          now_ms;
  } cls_t;

endpackage

// ===== rtl/wlfs_front.sv =====
`timescale 1ns / 1ps
module wlfs_front import wlfs_pkg::*; (
  input  req_t                   req,
  input  logic [CABLE_BITS-1:0]  zero_near_limit,
  output cls_t                   cls
);

  logic signed [LEVEL_BITS-1:0] level_adj;

  // Bias negative odd levels so the shift truncates toward zero
  assign level_adj = req.level_now +
                     LEVEL_BITS'(req.level_now[LEVEL_BITS-1] & req.level_now[0]);

  // Classify the request for the back end
  always_comb begin
    cls.action     = req.action;
    cls.in_water   = req.in_water;
    cls.near_zero  = (req.cable_len <= zero_near_limit);
    cls.level_half = level_adj >>> 1;
    cls.level_odd  = req.level_now[0];
    cls.now_ms     = req.now_ms;
  end

endmodule

// ===== rtl/wlfs_queue.sv =====
`timescale 1ns / 1ps
module wlfs_queue import wlfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cls_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(q_push_counts, clk, rst, push && !pop |=> count == $past(count) + CNT_W'(1), "queue count did not follow a push")
  `ASSERT_NEVER(q_pop_empty, clk, rst, pop && !not_empty, "queue popped while empty")

endmodule

// ===== rtl/wlfs_back.sv =====
`timescale 1ns / 1ps
module wlfs_back import wlfs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic [CABLE_BITS-1:0]     zero_near_limit,
  input  logic                      q_valid,
  input  cls_t                      head,
  output logic                      pop,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rsp_t                      rsp
);

  localparam int SPREAD_W = LEVEL_BITS + 2;

  logic [THRESH_BITS-1:0]        stable_threshold;
  logic [TIME_BITS-1:0]          window_len;

  logic                          searching, searching_next;
  logic                          moving_up, moving_up_next;
  logic                          have_flip, have_flip_next;
  logic signed [LEVEL_BITS-1:0]  prev_half, prev_half_next;
  logic                          prev_odd, prev_odd_next;
  logic signed [LEVEL_BITS-1:0]  window_min, window_min_next;
  logic signed [LEVEL_BITS-1:0]  window_max, window_max_next;
  logic [TIME_BITS-1:0]          window_start, window_start_next;
  rsp_t                          rsp_next;

  logic signed [LEVEL_BITS:0]    avg_sum;
  logic signed [LEVEL_BITS-1:0]  avg;
  logic signed [LEVEL_BITS-1:0]  upd_min;
  logic signed [LEVEL_BITS-1:0]  upd_max;
  logic signed [SPREAD_W-1:0]    spread;
  logic signed [SPREAD_W-1:0]    thresh_ext;
  logic [TIME_BITS-1:0]          elapsed;
  logic                          issue;

  assign pop = q_valid && (!rsp_valid || rsp_ready);

  // Average of the previous and current flip levels
  assign avg_sum = {prev_half[LEVEL_BITS-1], prev_half} +
                   {head.level_half[LEVEL_BITS-1], head.level_half} +
                   (LEVEL_BITS + 1)'(prev_odd & head.level_odd);
  assign avg     = avg_sum[LEVEL_BITS-1:0];

  // Window bounds including the new average
  assign upd_min    = (avg < window_min) ? avg : window_min;
  assign upd_max    = (avg > window_max) ? avg : window_max;
  assign spread     = {{2{upd_max[LEVEL_BITS-1]}}, upd_max} -
                      {{2{upd_min[LEVEL_BITS-1]}}, upd_min};
  assign thresh_ext = {{(SPREAD_W - THRESH_BITS){1'b0}}, stable_threshold};
  assign elapsed    = head.now_ms - window_start;

  // Decide the response and next search state
  always_comb begin
    searching_next    = searching;
    moving_up_next    = moving_up;
    have_flip_next    = have_flip;
    prev_half_next    = prev_half;
    prev_odd_next     = prev_odd;
    window_min_next   = window_min;
    window_max_next   = window_max;
    window_start_next = window_start;
    issue             = 1'b0;
    rsp_next.motor_cmd    = CMD_NONE;
    rsp_next.status       = ST_SEARCHING;
    rsp_next.level_valid  = 1'b0;
    rsp_next.level_avg    = '0;
    rsp_next.window_reset = 1'b0;

    if (head.action == ACT_START) begin
      searching_next    = 1'b1;
      have_flip_next    = 1'b0;
      moving_up_next    = head.in_water;
      window_min_next   = LEVEL_TOP;
      window_max_next   = LEVEL_BOTTOM;
      window_start_next = head.now_ms;
      issue             = 1'b1;
    end else if (!searching) begin
      rsp_next.status = ST_IDLE;
    end else if (head.in_water == moving_up) begin
      issue = 1'b1;
    end else begin
      moving_up_next = head.in_water;
      prev_half_next = head.level_half;
      prev_odd_next  = head.level_odd;
      if (!have_flip) begin
        have_flip_next    = 1'b1;
        window_start_next = head.now_ms;
        issue             = 1'b1;
      end else begin
        rsp_next.level_valid = 1'b1;
        rsp_next.level_avg   = avg;
        window_min_next      = upd_min;
        window_max_next      = upd_max;
        if (spread > thresh_ext) begin
          window_start_next     = head.now_ms;
          window_min_next       = avg;
          window_max_next       = avg;
          rsp_next.window_reset = 1'b1;
          issue                 = 1'b1;
        end else if (elapsed >= window_len) begin
          searching_next     = 1'b0;
          rsp_next.motor_cmd = CMD_SLOW_STOP;
          rsp_next.status    = ST_STABLE;
        end else begin
          issue = 1'b1;
        end
      end
    end

    // Pick the next step, stop if still wet near zero
    if (issue) begin
      if (moving_up_next) begin
        if (head.near_zero) begin
          searching_next     = 1'b0;
          rsp_next.motor_cmd = CMD_NONE;
          rsp_next.status    = ST_TOO_LOW;
        end else begin
          rsp_next.motor_cmd = CMD_UP;
        end
      end else begin
        rsp_next.motor_cmd = CMD_DOWN;
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_threshold <= THRESHOLD_RESET;
      window_len       <= WINDOW_RESET;
      zero_near_limit  <= NEAR_ZERO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STABLE_THRESHOLD: stable_threshold <= cfg_data[THRESH_BITS-1:0];
        REG_WINDOW_LEN:       window_len       <= cfg_data[TIME_BITS-1:0];
        REG_ZERO_NEAR_LIMIT:  zero_near_limit  <= cfg_data[CABLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance search state on each popped request
  always_ff @(posedge clk) begin
    if (rst) begin
      searching    <= 1'b0;
      moving_up    <= 1'b0;
      have_flip    <= 1'b0;
      prev_half    <= '0;
      prev_odd     <= 1'b0;
      window_min   <= LEVEL_TOP;
      window_max   <= LEVEL_BOTTOM;
      window_start <= '0;
    end else if (pop) begin
      searching    <= searching_next;
      moving_up    <= moving_up_next;
      have_flip    <= have_flip_next;
      prev_half    <= prev_half_next;
      prev_odd     <= prev_odd_next;
      window_min   <= window_min_next;
      window_max   <= window_max_next;
      window_start <= window_start_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(b_avg_only_searching, clk, rst, rsp_valid && rsp.level_valid |-> rsp.status != ST_IDLE, "average given outside a search")
  `ASSERT_CLK(b_wreset_has_avg, clk, rst, rsp_valid && rsp.window_reset |-> rsp.level_valid && rsp.status != ST_STABLE, "window restart without an average")
  `ASSERT_CLK(b_end_clears_search, clk, rst, pop && (rsp_next.status == ST_STABLE || rsp_next.status == ST_TOO_LOW) |=> !searching, "search still armed after it ended")

endmodule

// ===== rtl/water_level_flip_search.sv =====
`timescale 1ns / 1ps
// Water level flip search: a start request arms the search, each sample request
// reports the probe state after one motor step, and every request yields exactly
// one response with the next motor command, the status and, from the second
// wet/dry flip on, the averaged level. The block takes one request per cycle while
// the queue has room; each accepted request is written into the queue and, when
// popped, moves through the decision logic into the output register, from which
// its response is offered until it is taken.
// While a response is held, the two-entry queue keeps taking requests; once both
// entries are full the input stalls until the held response is taken.
// Configuration writes are always accepted and must only occur while idle.
module water_level_flip_search import wlfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rsp_t                      rsp
);

  cls_t                  cls;
  cls_t                  head;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  logic [CABLE_BITS-1:0] zero_near_limit;

  assign cfg_ready = 1'b1;
  assign req_ready = !q_full;

  wlfs_front u_front (
    .req             (req),
    .zero_near_limit (zero_near_limit),
    .cls             (cls)
  );

  wlfs_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && req_ready),
    .push_data (cls),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  wlfs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .zero_near_limit (zero_near_limit),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp)
  );

endmodule
